[sv/joint_steady_state_kalman_core_macros.svh]
// Assertion macros for the checker file of the joint filter core.
`ifndef JOINT_STEADY_STATE_KALMAN_CORE_MACROS_SVH
`define JOINT_STEADY_STATE_KALMAN_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define JSSK_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define JSSK_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define JSSK_ASSERT_NEXT_ALWAYS(label, clk, pre, post, msg) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error(msg);

`endif

[sv/jssk_pkg.sv]
package jssk_pkg;

   localparam int NUM_JOINTS = 32;
   localparam int JOINT_W    = 5;
   localparam int ADDR_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int RANGE_W    = 9;
   localparam int DATA_W     = 32;
   localparam int FRAC       = 16;
   localparam int STEP_W     = 16;
   localparam int GPOS_W     = 17;
   localparam int GVEL_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int SAT_W      = 43;

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd66;

   localparam logic signed [SAT_W-1:0] SAT_MAX = 43'sd2147483647;
   localparam logic signed [SAT_W-1:0] SAT_MIN = -43'sd2147483648;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_TIME = 2'd0,
      CSR_GAIN_POS  = 2'd1,
      CSR_GAIN_VEL  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [JOINT_W-1:0]       joint_index;
      logic signed [DATA_W-1:0] meas_position;
      logic signed [DATA_W-1:0] accel_input;
   } jssk_req_type;

   typedef struct packed {
      logic [JOINT_W-1:0]       out_joint;
      logic signed [DATA_W-1:0] est_position;
      logic signed [DATA_W-1:0] est_velocity;
   } jssk_rsp_type;

   // Load enables of the arithmetic stages.
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } jssk_stage_en_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > SAT_MAX) begin
         r = SAT_MAX[DATA_W-1:0];
      end else if (x < SAT_MIN) begin
         r = SAT_MIN[DATA_W-1:0];
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic joint_in_range(input logic [JOINT_W-1:0] idx);
      return RANGE_W'(idx) < RANGE_W'(NUM_JOINTS);
   endfunction

endpackage

[sv/joint_steady_state_kalman_core.sv]
// An input transfer passes the store read in stage 1, the arithmetic in stages 2 to 4 and
// the output register in stage 5, which drives rsp_valid and holds while rsp_ready is low.
// Throughput: one item per cycle while the output is not stalled and the joint matches no live item in stages 1 to 4.
// A repeated joint waits until the earlier item of that joint has written the joint store,
// as it leaves stage 4; that read-modify-write loop through the store sets the rate.
// Reset clears the pipeline, reloads step_time with 66 and both gains with 0, and empties
// the joint store at once through per-joint valid bits, so no clearing pass follows reset.
module joint_steady_state_kalman_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  jssk_pkg::jssk_req_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output jssk_pkg::jssk_rsp_type              rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jssk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jssk_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import jssk_pkg::*;

   // Per-stage bookkeeping that travels beside the arithmetic: the joint number and whether
   // it names a real joint, so that only a real joint writes the store.
   typedef struct packed {
      logic               live;
      logic [JOINT_W-1:0] joint;
   } tag_type;

   // Configuration registers. Writes are accepted in any cycle; software only writes them
   // while no item is in flight.
   logic [STEP_W-1:0] step_time_ff;
   logic [GPOS_W-1:0] gain_pos_ff;
   logic [GVEL_W-1:0] gain_vel_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_RESET;
         gain_pos_ff  <= '0;
         gain_vel_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STEP_TIME: step_time_ff <= csr_wdata[STEP_W-1:0];
            CSR_GAIN_POS:  gain_pos_ff  <= csr_wdata[GPOS_W-1:0];
            CSR_GAIN_VEL:  gain_vel_ff  <= csr_wdata[GVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline occupancy. Stage 1 holds the store read, stage 5 is the output register.
   // A stage can take a new item when it is empty or its own item moves on this cycle,
   // so bubbles collapse and the input side keeps accepting while a result waits, until stages fill.
   logic [5:1] vld_ff;
   logic [5:1] go;
   tag_type    tag_ff [1:5];
   logic       hazard;
   logic       accept;
   jssk_stage_en_type en;

   always_comb begin
      go[5] = !vld_ff[5] || rsp_ready;
      go[4] = !vld_ff[4] || go[5];
      go[3] = !vld_ff[3] || go[4];
      go[2] = !vld_ff[2] || go[3];
      go[1] = !vld_ff[1] || go[2];
   end

   // Interlock: a joint that is still being updated in stages 1 to 4 has not yet been
   // written back, so a new sample of that joint is held off until the write completes.
   // This also keeps the live joints in stages 1 to 4 distinct, so a stalled store read never goes stale.
   always_comb begin
      hazard = 1'b0;
      for (int k = 1; k <= 4; k++) begin
         if (vld_ff[k] && tag_ff[k].live && (tag_ff[k].joint == req_payload.joint_index)) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_ready = go[1] && !hazard;
   assign accept    = req_valid && req_ready;

   assign en.s2 = go[2] && vld_ff[1];
   assign en.s3 = go[3] && vld_ff[2];
   assign en.s4 = go[4] && vld_ff[3];
   assign en.s5 = go[5] && vld_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (go[1]) begin
            vld_ff[1] <= accept;
         end
         if (go[2]) begin
            vld_ff[2] <= vld_ff[1];
         end
         if (go[3]) begin
            vld_ff[3] <= vld_ff[2];
         end
         if (go[4]) begin
            vld_ff[4] <= vld_ff[3];
         end
         if (go[5]) begin
            vld_ff[5] <= vld_ff[4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff[1] <= '{live: joint_in_range(req_payload.joint_index),
                        joint: req_payload.joint_index};
      end
      if (en.s2) begin
         tag_ff[2] <= tag_ff[1];
      end
      if (en.s3) begin
         tag_ff[3] <= tag_ff[2];
      end
      if (en.s4) begin
         tag_ff[4] <= tag_ff[3];
      end
      if (en.s5) begin
         tag_ff[5] <= tag_ff[4];
      end
   end

   // Joint store: position in the upper half of each word, velocity in the lower half.
   // A joint that has never been written since reset reads as zero through its valid bit.
   logic [NUM_JOINTS-1:0]     written_ff;
   logic                      written1_ff;
   logic signed [DATA_W-1:0]  meas1_ff, accel1_ff;
   logic [2*DATA_W-1:0]       rd_data;
   logic                      wr_en;
   logic [ADDR_W-1:0]         rd_addr, wr_addr;
   logic signed [DATA_W-1:0]  pos1, vel1;
   logic signed [DATA_W-1:0]  wb_pos, wb_vel, est_pos, est_vel;

   assign rd_addr = ADDR_W'(req_payload.joint_index);
   assign wr_addr = ADDR_W'(tag_ff[4].joint);
   assign wr_en   = en.s5 && tag_ff[4].live;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         written1_ff <= written_ff[rd_addr];
         meas1_ff    <= req_payload.meas_position;
         accel1_ff   <= req_payload.accel_input;
      end
   end

   jssk_ram #(
      .WIDTH (2 * DATA_W),
      .DEPTH (NUM_JOINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wb_pos, wb_vel}),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pos1 = written1_ff ? $signed(rd_data[2*DATA_W-1:DATA_W]) : '0;
   assign vel1 = written1_ff ? $signed(rd_data[DATA_W-1:0]) : '0;

   // Stage 2 forms dt*v and dt*a, stage 3 the saturated prediction and the innovation,
   // stage 4 the two gain products, and the step into stage 5 the corrected state.
   jssk_datapath u_datapath (
      .clock     (clock),
      .en        (en),
      .step_time (step_time_ff),
      .gain_pos  (gain_pos_ff),
      .gain_vel  (gain_vel_ff),
      .pos_in    (pos1),
      .vel_in    (vel1),
      .meas_in   (meas1_ff),
      .accel_in  (accel1_ff),
      .wb_pos    (wb_pos),
      .wb_vel    (wb_vel),
      .est_pos   (est_pos),
      .est_vel   (est_vel)
   );

   // A sample for a joint beyond the store returns zeros and leaves the store alone.
   assign rsp_valid                = vld_ff[5];
   assign rsp_payload.out_joint    = tag_ff[5].joint;
   assign rsp_payload.est_position = tag_ff[5].live ? est_pos : '0;
   assign rsp_payload.est_velocity = tag_ff[5].live ? est_vel : '0;

endmodule

[sv/jssk_ram.sv]
module jssk_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/jssk_datapath.sv]
module jssk_datapath (
   input  logic                                    clock,
   input  jssk_pkg::jssk_stage_en_type             en,
   input  logic [jssk_pkg::STEP_W-1:0]             step_time,
   input  logic [jssk_pkg::GPOS_W-1:0]             gain_pos,
   input  logic [jssk_pkg::GVEL_W-1:0]             gain_vel,
   input  logic signed [jssk_pkg::DATA_W-1:0]      pos_in,
   input  logic signed [jssk_pkg::DATA_W-1:0]      vel_in,
   input  logic signed [jssk_pkg::DATA_W-1:0]      meas_in,
   input  logic signed [jssk_pkg::DATA_W-1:0]      accel_in,
   output logic signed [jssk_pkg::DATA_W-1:0]      wb_pos,
   output logic signed [jssk_pkg::DATA_W-1:0]      wb_vel,
   output logic signed [jssk_pkg::DATA_W-1:0]      est_pos,
   output logic signed [jssk_pkg::DATA_W-1:0]      est_vel
);
   import jssk_pkg::*;

   localparam int DTP_W = STEP_W + 1 + DATA_W;
   localparam int ERR_W = DATA_W + 1;
   localparam int GPP_W = GPOS_W + 1 + ERR_W;
   localparam int GVP_W = GVEL_W + 1 + ERR_W;
   localparam int PSUM_W = DATA_W + 2;
   localparam int GSUM_W = DATA_W + 4;

   // Stage 2: prediction products.
   logic signed [DTP_W-1:0]  pv_prod_in, pv_prod_ff;
   logic signed [DTP_W-1:0]  va_prod_in, va_prod_ff;
   logic signed [DATA_W-1:0] pos2_ff, vel2_ff, meas2_ff;

   // Stage 3: predicted state and innovation.
   logic signed [PSUM_W-1:0] pp_sum, vp_sum;
   logic signed [DATA_W-1:0] pp3_in, pp3_ff, vp3_in, vp3_ff;
   logic signed [ERR_W-1:0]  err3_in, err3_ff;

   // Stage 4: correction products.
   logic signed [GPP_W-1:0]  gp_prod_in, gp_prod_ff;
   logic signed [GVP_W-1:0]  gv_prod_in, gv_prod_ff;
   logic signed [DATA_W-1:0] pp4_ff, vp4_ff;

   // Stage 5: corrected state.
   logic signed [GSUM_W-1:0] pn_sum;
   logic signed [SAT_W-1:0]  vn_sum;
   logic signed [DATA_W-1:0] pos5_ff, vel5_ff;

   assign pv_prod_in = DTP_W'($signed({1'b0, step_time})) * DTP_W'(vel_in);
   assign va_prod_in = DTP_W'($signed({1'b0, step_time})) * DTP_W'(accel_in);

   assign pp_sum  = PSUM_W'(pos2_ff) + PSUM_W'(pv_prod_ff >>> FRAC);
   assign vp_sum  = PSUM_W'(vel2_ff) + PSUM_W'(va_prod_ff >>> FRAC);
   assign pp3_in  = sat32(SAT_W'(pp_sum));
   assign vp3_in  = sat32(SAT_W'(vp_sum));
   assign err3_in = ERR_W'(meas2_ff) - ERR_W'(pp3_in);

   assign gp_prod_in = GPP_W'($signed({1'b0, gain_pos})) * GPP_W'(err3_ff);
   assign gv_prod_in = GVP_W'($signed({1'b0, gain_vel})) * GVP_W'(err3_ff);

   assign pn_sum = GSUM_W'(pp4_ff) + GSUM_W'(gp_prod_ff >>> FRAC);
   assign vn_sum = SAT_W'(vp4_ff) + SAT_W'(gv_prod_ff >>> FRAC);
   assign wb_pos = sat32(SAT_W'(pn_sum));
   assign wb_vel = sat32(vn_sum);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         pv_prod_ff <= pv_prod_in;
         va_prod_ff <= va_prod_in;
         pos2_ff    <= pos_in;
         vel2_ff    <= vel_in;
         meas2_ff   <= meas_in;
      end
      if (en.s3) begin
         pp3_ff  <= pp3_in;
         vp3_ff  <= vp3_in;
         err3_ff <= err3_in;
      end
      if (en.s4) begin
         gp_prod_ff <= gp_prod_in;
         gv_prod_ff <= gv_prod_in;
         pp4_ff     <= pp3_ff;
         vp4_ff     <= vp3_ff;
      end
      if (en.s5) begin
         pos5_ff <= wb_pos;
         vel5_ff <= wb_vel;
      end
   end

   assign est_pos = pos5_ff;
   assign est_vel = vel5_ff;

endmodule

[sv/jssk_checker.sv]
`include "joint_steady_state_kalman_core_macros.svh"

module jssk_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input jssk_pkg::jssk_req_type              req_payload,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input jssk_pkg::jssk_rsp_type              rsp_payload
);
   import jssk_pkg::*;

   logic req_xfer;
   logic live_xfer;

   assign req_xfer  = req_valid && req_ready;
   assign live_xfer = req_xfer && joint_in_range(req_payload.joint_index);

   // A result that is not taken stays, unchanged.
   `JSSK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // Reset empties the pipeline by the next cycle.
   `JSSK_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result pending after reset")

   // With the pipeline empty after reset, the input side is open.
   `JSSK_ASSERT_SAME(a_ready_after_reset, clock, reset, $fell(reset), req_ready, "input not ready after reset")

   // Two samples of one joint never enter on consecutive cycles: the second must wait for
   // the write-back of the first.
   `JSSK_ASSERT_NEXT(a_joint_interlock, clock, reset, live_xfer, !(req_xfer && (req_payload.joint_index == $past(req_payload.joint_index))), "same joint accepted back to back")

endmodule

bind joint_steady_state_kalman_core jssk_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

[tb/joint_steady_state_kalman_core_checker.sv]
`timescale 1ns / 100ps

module joint_steady_state_kalman_core_checker
   import jssk_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  jssk_req_type           req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  jssk_rsp_type           rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     estimates_pending
);

   localparam longint WORD_CEIL  = 64'sd2147483647;
   localparam longint WORD_FLOOR = -64'sd2147483648;

   logic [STEP_W-1:0]         step_time;
   logic [GPOS_W-1:0]         gain_pos;
   logic [GVEL_W-1:0]         gain_vel;
   logic signed [DATA_W-1:0]  position_store [NUM_JOINTS];
   logic signed [DATA_W-1:0]  velocity_store [NUM_JOINTS];
   jssk_rsp_type              expected_estimates [$];

   function automatic longint clamp_word(input longint x);
      if (x > WORD_CEIL) begin
         return WORD_CEIL;
      end
      if (x < WORD_FLOOR) begin
         return WORD_FLOOR;
      end
      return x;
   endfunction

   // Predict-then-correct update of one joint; the arithmetic shift on a signed
   // 64-bit product rounds toward minus infinity, as the datapath does.
   function automatic jssk_rsp_type filter_update(input jssk_req_type sample);
      jssk_rsp_type estimate;
      longint pos, vel, dt, meas, accel, gp, gv, pos_pred, vel_pred, innov;
      estimate.out_joint    = sample.joint_index;
      estimate.est_position = '0;
      estimate.est_velocity = '0;
      if (sample.joint_index < NUM_JOINTS) begin
         pos   = longint'(position_store[sample.joint_index]);
         vel   = longint'(velocity_store[sample.joint_index]);
         dt    = longint'(step_time);
         gp    = longint'(gain_pos);
         gv    = longint'(gain_vel);
         meas  = longint'(sample.meas_position);
         accel = longint'(sample.accel_input);
         pos_pred = clamp_word(pos + ((dt * vel) >>> FRAC));
         vel_pred = clamp_word(vel + ((dt * accel) >>> FRAC));
         innov    = meas - pos_pred;
         pos      = clamp_word(pos_pred + ((gp * innov) >>> FRAC));
         vel      = clamp_word(vel_pred + ((gv * innov) >>> FRAC));
         position_store[sample.joint_index] = pos[DATA_W-1:0];
         velocity_store[sample.joint_index] = vel[DATA_W-1:0];
         estimate.est_position = pos[DATA_W-1:0];
         estimate.est_velocity = vel[DATA_W-1:0];
      end
      return estimate;
   endfunction

   always @(posedge clock) begin
      jssk_rsp_type want;
      if (reset) begin
         step_time = STEP_RESET;
         gain_pos  = '0;
         gain_vel  = '0;
         for (int j = 0; j < NUM_JOINTS; j++) begin
            position_store[j] = '0;
            velocity_store[j] = '0;
         end
         expected_estimates.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STEP_TIME: begin
                  step_time = csr_wdata[STEP_W-1:0];
               end
               CSR_GAIN_POS: begin
                  gain_pos = csr_wdata[GPOS_W-1:0];
               end
               CSR_GAIN_VEL: begin
                  gain_vel = csr_wdata[GVEL_W-1:0];
               end
               default: begin
               end
            endcase
         end
         // Results are matched before the new sample is queued; the pipeline
         // latency keeps a same-edge sample from being the one returned.
         if (rsp_valid && rsp_ready) begin
            if (expected_estimates.size() == 0) begin
               $error("unexpected result transfer: out_joint %0d", rsp_payload.out_joint);
               mismatch_count++;
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_payload.out_joint !== want.out_joint) begin
                  $error("out_joint: expected %0d, actual %0d",
                         want.out_joint, rsp_payload.out_joint);
                  mismatch_count++;
               end
               if (rsp_payload.est_position !== want.est_position) begin
                  $error("est_position: expected %0d, actual %0d",
                         want.est_position, rsp_payload.est_position);
                  mismatch_count++;
               end
               if (rsp_payload.est_velocity !== want.est_velocity) begin
                  $error("est_velocity: expected %0d, actual %0d",
                         want.est_velocity, rsp_payload.est_velocity);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_estimates.push_back(filter_update(req_payload));
         end
      end
      estimates_pending <= expected_estimates.size();
   end

endmodule

[tb/joint_steady_state_kalman_core_tb.sv]
`timescale 1ns / 100ps

module joint_steady_state_kalman_core_tb;
   import jssk_pkg::*;

   // Eight random phases of this many samples follow the directed opening.
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 205;
   // This pause lets the pipeline empty after the last result, with margin.
   localparam int SETTLE_CYCLES   = 12;
   // Cycles with no transfer on any channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT  = 4000;

   // Register index that the core does not decode; a write to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   jssk_req_type           req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b1;
   jssk_rsp_type           rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   int mismatch_count;
   int estimates_pending;
   int idle_cycles = 0;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   always #1 clock = ~clock;

   joint_steady_state_kalman_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   joint_steady_state_kalman_core_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .estimates_pending (estimates_pending)
   );

   // The receiver decides afresh every cycle whether it can take a result.
   // Since ready may drop while a result waits, stalls land on every pipeline phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Hang detection: any transfer on any channel restarts the count. A missing
   // result leaves the drain wait spinning, which ends here as a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly small positions and accelerations, so the state evolves the way a real
   // joint would; a quarter are full-range words that flip every bit, and a few are
   // the limits of the word, zero or minus one, so that both saturation directions get hit.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 25) begin
         return $urandom;
      end
      if (roll < 35) begin
         case ($urandom_range(3))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            default: return -1;
         endcase
      end
      return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sd1048576;
   endfunction

   // One sample transfer. Valid goes up without looking at ready and then holds
   // with a steady payload until the core takes the sample. A follow-on call
   // keeps valid high when it draws no idle gap, so back-to-back samples then see no dip in valid.
   task automatic send_sample(input logic [JOINT_W-1:0] joint,
                              input logic signed [DATA_W-1:0] meas,
                              input logic signed [DATA_W-1:0] accel);
      jssk_req_type sample;
      sample.joint_index   = joint;
      sample.meas_position = meas;
      sample.accel_input   = accel;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= sample;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Stops the sender and waits until every predicted estimate has come back,
   // then lets the pipeline settle so the core is truly idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (estimates_pending != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register transfer. Valid is left high so that the next write follows
   // without a gap; the caller lowers it after the last one.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   // Loads a full filter setting. Bits above each register's width are passed
   // through so that the core is seen to drop them.
   task automatic configure(input logic [CSR_DATA_W-1:0] step_word,
                            input logic [CSR_DATA_W-1:0] gpos_word,
                            input logic [CSR_DATA_W-1:0] gvel_word,
                            input bit poke_unused);
      write_reg(CSR_STEP_TIME, step_word);
      write_reg(CSR_GAIN_POS, gpos_word);
      write_reg(CSR_GAIN_VEL, gvel_word);
      if (poke_unused) begin
         write_reg(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] step_word;
      logic [CSR_DATA_W-1:0] gpos_word;
      logic [CSR_DATA_W-1:0] gvel_word;
      logic [JOINT_W-1:0]    joint;
      int unsigned           roll;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening. With the reset setting (a 66 step, both gains zero)
      // the outputs are pure prediction, which shows the reset step value.
      send_sample(5'd0, 32'sd65536, 32'sd65536);
      send_sample(5'd0, 32'sd0, 32'sd65536);
      send_sample(5'd0, -32'sd65536, -32'sd131072);
      drain_results();

      // Largest step and both gains at full scale: the position gain is almost
      // two, above one, and the core must use it as loaded. The unused
      // register index is written too and must change nothing.
      configure(24'h00FFFF, 24'h01FFFF, 24'hFFFFFF, 1'b1);
      send_sample(5'd1, WORD_MAX, WORD_MAX);
      send_sample(5'd1, WORD_MAX, WORD_MAX);
      send_sample(5'd1, WORD_MIN, WORD_MIN);
      send_sample(5'd1, WORD_MIN, WORD_MIN);
      send_sample(5'd31, -32'sd1, -32'sd1);
      send_sample(5'd31, WORD_MAX, WORD_MIN);
      send_sample(5'd30, WORD_MIN, WORD_MAX);
      send_sample(5'd31, 32'sd0, 32'sd0);
      send_sample(5'd2, 32'sd1, 32'sd0);
      send_sample(5'd3, 32'sd12345, -32'sd54321);
      send_sample(5'd2, 32'sd1, 32'sd0);
      send_sample(5'd16, 32'sh5555_5555, 32'shAAAA_AAAA);
      send_sample(5'd15, 32'shAAAA_AAAA, 32'sh5555_5555);
      drain_results();

      joint = '0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // Settings rotate through typical, zero, full-scale and random values.
         case (phase)
            0: begin
               step_word = 24'd655;
               gpos_word = 24'd6554;
               gvel_word = 24'd32768;
            end
            1: begin
               step_word = '0;
               gpos_word = '0;
               gvel_word = '0;
            end
            2: begin
               step_word = 24'h00FFFF;
               gpos_word = 24'h010000;
               gvel_word = 24'hFFFFFF;
            end
            4: begin
               step_word = 24'hFFFFFF;
               gpos_word = 24'hFFFFFF;
               gvel_word = 24'h000001;
            end
            default: begin
               step_word = CSR_DATA_W'($urandom);
               gpos_word = CSR_DATA_W'($urandom);
               gvel_word = CSR_DATA_W'($urandom);
            end
         endcase
         configure(step_word, gpos_word, gvel_word, (phase % 3) == 2);

         // Traffic shape of this phase: free-running, sender gaps, receiver
         // stalls, then both at once.
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 48;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 48;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
         endcase

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Round-robin sweeps as a sensor bus would deliver them, mixed with
            // runs on one joint that stress the store read-after-write hazard.
            roll = $urandom_range(99);
            if (roll < 40) begin
               joint = joint + 1'b1;
            end else if (roll >= 70) begin
               joint = JOINT_W'($urandom_range(NUM_JOINTS - 1));
            end
            // Halfway through, hold the sender off until the core has emptied.
            if (n == ITEMS_PER_PHASE / 2) begin
               drain_results();
            end
            send_sample(joint, pick_value(), pick_value());
         end
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/jssk_pkg.sv
sv/jssk_ram.sv
sv/jssk_datapath.sv
sv/joint_steady_state_kalman_core.sv
sv/jssk_checker.sv
tb/joint_steady_state_kalman_core_checker.sv
tb/joint_steady_state_kalman_core_tb.sv
